>>> hdl/svpd_pkg.sv
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared widths, constants and helpers for the space vector PWM duty block.
// ----------------------------------------------------------------------------
package svpd_pkg;

  // field widths
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned DUTY_W = 15;
  localparam int unsigned CODE_W = 3;

  // internal widths
  localparam int unsigned FRAC_W = 14;   // Q14 fraction bits
  localparam int unsigned TIME_W = 16;   // rounded active time, up to about 44800
  localparam int unsigned SUM_W  = 17;   // sum of two active times
  localparam int unsigned U_W    = 32;   // Q28 reference voltages

  // serial multiplier operand widths
  localparam int unsigned MUL_MCAND_W  = 17;
  localparam int unsigned MUL_MPLIER_W = 15;

  // period, sqrt(3)/2 in Q14, rounding half in Q28 -> Q14
  localparam int unsigned PERIOD     = 16384;
  localparam int unsigned K_SQRT3_2  = 14189;
  localparam int unsigned ROUND_HALF = 8192;

  // serial divider: quotient bits of PERIOD*PERIOD / sum
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // sector sign codes u1 + 2*u2 + 4*u3
  localparam logic [CODE_W-1:0] SECT_NONE = 3'd0;
  localparam logic [CODE_W-1:0] SECT_U1   = 3'd1;
  localparam logic [CODE_W-1:0] SECT_U2   = 3'd2;
  localparam logic [CODE_W-1:0] SECT_U12  = 3'd3;
  localparam logic [CODE_W-1:0] SECT_U3   = 3'd4;
  localparam logic [CODE_W-1:0] SECT_U13  = 3'd5;
  localparam logic [CODE_W-1:0] SECT_U23  = 3'd6;
  localparam logic [CODE_W-1:0] SECT_ALL  = 3'd7;

  // round a Q28 value to Q14, nonpositive values give zero
  function automatic logic [TIME_W-1:0] round_q14(input logic signed [U_W-1:0] v);
    logic [U_W-1:0] r;
    r = $unsigned(v) + U_W'(ROUND_HALF);
    if (v[U_W-1] || (v == '0)) begin
      return '0;
    end
    return r[FRAC_W +: TIME_W];
  endfunction

endpackage

>>> hdl/svpd_if.sv
// ----------------------------------------------------------------------------
// svpd channel interfaces
// Valid/ready channels for the voltage command beat and the duty result beat.
// ----------------------------------------------------------------------------
interface svpd_in_if
  import svpd_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] volt_alpha;
  logic signed [VOLT_W-1:0] volt_beta;

  modport source (output valid, output volt_alpha, output volt_beta, input ready);
  modport sink   (input valid, input volt_alpha, input volt_beta, output ready);
endinterface

interface svpd_out_if
  import svpd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [DUTY_W-1:0] duty_c;
  logic [CODE_W-1:0] sector_code;
  logic              overmodulated;
  logic [DUTY_W-1:0] scale_factor;

  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output sector_code, output overmodulated, output scale_factor,
                  input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input sector_code, input overmodulated, input scale_factor,
                  output ready);
endinterface

>>> hdl/svpd_mul.sv
// ----------------------------------------------------------------------------
// svpd_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module svpd_mul
  import svpd_pkg::*;
#(
  parameter int unsigned McandW  = MUL_MCAND_W,
  parameter int unsigned MplierW = MUL_MPLIER_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [McandW-1:0]          mcand_i,
  input  logic [MplierW-1:0]         mplier_i,
  output logic                       done_o,
  output logic [McandW+MplierW-1:0]  prod_o
);

  localparam int unsigned ProdW = McandW + MplierW;
  localparam int unsigned CntW  = $clog2(MplierW + 1);

  logic [McandW-1:0] mcand_q;
  logic [ProdW-1:0]  prod_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q;
  logic [McandW:0]   hi_sum;

  // add the multiplicand into the upper half when the current bit is set
  always_comb begin
    hi_sum = {1'b0, prod_q[ProdW-1:MplierW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  end

  // low half starts as the multiplier and shifts out one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q <= '0;
      prod_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      mcand_q <= mcand_i;
      prod_q  <= {{McandW{1'b0}}, mplier_i};
      cnt_q   <= CntW'(MplierW);
      done_q  <= 1'b0;
    end else if (cnt_q != '0) begin
      prod_q  <= {hi_sum, prod_q[MplierW-1:1]};
      cnt_q   <= cnt_q - 1'b1;
      done_q  <= (cnt_q == CntW'(1));
    end else begin
      done_q  <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

>>> hdl/space_vector_pwm_duty.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Seven-segment space vector PWM duties from an alpha/beta voltage command.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one voltage command beat (volt_alpha, volt_beta, signed
//   Q2.14). out_o returns one beat per command: duties for phases A, B, C,
//   the sector sign code, the overmodulation flag and the last scale factor.
//   One command is worked on at a time; in_i.ready is high while no command
//   is in progress, also while a finished beat still waits on out_o.
//   A zero vector skips the zero-time step, and a command whose active times
//   need overmodulation scaling also passes through the divider and the
//   scaling multipliers. The bit-serial multiplier forms alpha*sqrt3/2 and,
//   for the scaling, both scaled active times in parallel; the bit-serial
//   divider forms period/sum. A new command is taken the cycle after the
//   previous result is loaded into the output register.
//   When out_o.ready is low the result register holds its beat; a finished
//   second result waits in the last step until the register frees up.
//   Reset clears the held duties to 0 and the scale factor to one (16384).
// ----------------------------------------------------------------------------
module space_vector_pwm_duty
  import svpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  svpd_in_if.sink     in_i,
  svpd_out_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_UVEC,
    ST_QSEL,
    ST_TIME,
    ST_CHECK,
    ST_DIV,
    ST_SCALE,
    ST_ZERO,
    ST_DUTY
  } state_e;

  localparam int unsigned ProdW = MUL_MCAND_W + MUL_MPLIER_W;

  state_e                  state_q;
  logic                    alpha_neg_q;
  logic signed [VOLT_W-1:0] beta_q;
  logic signed [U_W-1:0]   p_q, pn_q;
  logic signed [U_W-1:0]   u1_q, u2_q, u3_q;
  logic signed [U_W-1:0]   qx_q, qy_q;
  logic [CODE_W-1:0]       code_q;
  logic [TIME_W-1:0]       tx_q, ty_q;
  logic [SUM_W-1:0]        div_den_q;
  logic [SUM_W-1:0]        div_rem_q;
  logic [DUTY_W-1:0]       div_quot_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  logic [DUTY_W-1:0]       sxy_q, t7_q;
  logic                    over_q, hold_q;
  logic [DUTY_W-1:0]       held_a_q, held_b_q, held_c_q, last_scale_q;
  logic                    out_valid_q;
  logic [DUTY_W-1:0]       out_a_q, out_b_q, out_c_q, out_scale_q;
  logic [CODE_W-1:0]       out_code_q;
  logic                    out_over_q;

  logic                       accept;
  logic                       out_free;
  logic                       out_load;
  logic [MUL_MCAND_W-1:0]     alpha_ext, abs_alpha;
  logic                       mul0_start, mul1_start, mul0_done, mul1_done;
  logic [MUL_MCAND_W-1:0]     mul0_mcand;
  logic [MUL_MPLIER_W-1:0]    mul0_mplier;
  logic [ProdW-1:0]           mul0_prod, mul1_prod;
  logic signed [U_W-1:0]      prod_s, beta_q28, beta_q27;
  logic [CODE_W-1:0]          code_d;
  logic signed [U_W-1:0]      qx_d, qy_d;
  logic [SUM_W-1:0]           sum_t, sum_s, zero_t;
  logic [SUM_W:0]             div_shift;
  logic                       div_ge;
  logic [SUM_W-1:0]           div_rem_d;
  logic [DUTY_W-1:0]          div_quot_d;
  logic                       div_last;
  logic [DUTY_W-1:0]          full_t, ty_t7;
  logic [DUTY_W-1:0]          duty_a_d, duty_b_d, duty_c_d;

  // handshake
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == ST_DUTY) && out_free;

  // magnitude of alpha for the unsigned serial multiplier
  assign alpha_ext = {in_i.volt_alpha[VOLT_W-1], in_i.volt_alpha};
  assign abs_alpha = in_i.volt_alpha[VOLT_W-1] ? (~alpha_ext + 1'b1) : alpha_ext;

  // multiplier operands: alpha*sqrt3/2 at accept, then tx*scale / ty*scale
  assign div_last    = (state_q == ST_DIV) && (div_cnt_q == DIV_CNT_W'(1));
  assign mul0_start  = accept || div_last;
  assign mul1_start  = div_last;
  assign mul0_mcand  = (state_q == ST_IDLE) ? abs_alpha : {1'b0, tx_q};
  assign mul0_mplier = (state_q == ST_IDLE) ? MUL_MPLIER_W'(K_SQRT3_2) : div_quot_d;

  svpd_mul #(
    .McandW  (MUL_MCAND_W),
    .MplierW (MUL_MPLIER_W)
  ) u_mul0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul0_start),
    .mcand_i  (mul0_mcand),
    .mplier_i (mul0_mplier),
    .done_o   (mul0_done),
    .prod_o   (mul0_prod)
  );

  svpd_mul #(
    .McandW  (MUL_MCAND_W),
    .MplierW (MUL_MPLIER_W)
  ) u_mul1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul1_start),
    .mcand_i  ({1'b0, ty_q}),
    .mplier_i (div_quot_d),
    .done_o   (mul1_done),
    .prod_o   (mul1_prod)
  );

  // beta terms in Q28
  assign prod_s   = $signed(mul0_prod[U_W-1:0]);
  assign beta_q28 = {{(U_W-VOLT_W-FRAC_W){beta_q[VOLT_W-1]}}, beta_q, {FRAC_W{1'b0}}};
  assign beta_q27 = {{(U_W-VOLT_W-FRAC_W+1){beta_q[VOLT_W-1]}}, beta_q,
                     {(FRAC_W-1){1'b0}}};

  // sector code and active-time operands
  always_comb begin
    code_d = {(!u3_q[U_W-1] && (u3_q != '0)),
              (!u2_q[U_W-1] && (u2_q != '0)),
              (!u1_q[U_W-1] && (u1_q != '0))};
    case (code_d)
      SECT_U13: begin qx_d = u3_q;  qy_d = u1_q;  end
      SECT_U1:  begin qx_d = -u3_q; qy_d = -u2_q; end
      SECT_U12: begin qx_d = u1_q;  qy_d = u2_q;  end
      SECT_U2:  begin qx_d = -u1_q; qy_d = -u3_q; end
      SECT_U23: begin qx_d = u2_q;  qy_d = u3_q;  end
      default:  begin qx_d = -u2_q; qy_d = -u1_q; end
    endcase
  end

  // time sums and zero time
  assign sum_t  = SUM_W'(tx_q) + SUM_W'(ty_q);
  assign sum_s  = sum_t;
  assign zero_t = SUM_W'(PERIOD) - sum_s;

  // one restoring divide step
  always_comb begin
    div_shift = {div_rem_q, 1'b0};
    div_ge    = (div_shift >= {1'b0, div_den_q});
    if (div_ge) begin
      div_rem_d = SUM_W'(div_shift - {1'b0, div_den_q});
    end else begin
      div_rem_d = div_shift[SUM_W-1:0];
    end
    div_quot_d = {div_quot_q[DUTY_W-2:0], div_ge};
  end

  // seven-segment duty assignment per sector
  assign full_t = sxy_q + t7_q;
  assign ty_t7  = DUTY_W'(ty_q) + t7_q;

  always_comb begin
    case (code_q)
      SECT_U13: begin duty_a_d = full_t; duty_b_d = ty_t7;  duty_c_d = t7_q;   end
      SECT_U1:  begin duty_a_d = ty_t7;  duty_b_d = full_t; duty_c_d = t7_q;   end
      SECT_U12: begin duty_a_d = t7_q;   duty_b_d = full_t; duty_c_d = ty_t7;  end
      SECT_U2:  begin duty_a_d = t7_q;   duty_b_d = ty_t7;  duty_c_d = full_t; end
      SECT_U23: begin duty_a_d = ty_t7;  duty_b_d = t7_q;   duty_c_d = full_t; end
      default:  begin duty_a_d = full_t; duty_b_d = t7_q;   duty_c_d = ty_t7;  end
    endcase
  end

  // sequencer, held state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      alpha_neg_q  <= 1'b0;
      beta_q       <= '0;
      p_q          <= '0;
      pn_q         <= '0;
      u1_q         <= '0;
      u2_q         <= '0;
      u3_q         <= '0;
      qx_q         <= '0;
      qy_q         <= '0;
      code_q       <= SECT_NONE;
      tx_q         <= '0;
      ty_q         <= '0;
      div_den_q    <= '0;
      div_rem_q    <= '0;
      div_quot_q   <= '0;
      div_cnt_q    <= '0;
      sxy_q        <= '0;
      t7_q         <= '0;
      over_q       <= 1'b0;
      hold_q       <= 1'b0;
      held_a_q     <= '0;
      held_b_q     <= '0;
      held_c_q     <= '0;
      last_scale_q <= DUTY_W'(PERIOD);
      out_valid_q  <= 1'b0;
      out_a_q      <= '0;
      out_b_q      <= '0;
      out_c_q      <= '0;
      out_code_q   <= SECT_NONE;
      out_over_q   <= 1'b0;
      out_scale_q  <= '0;
    end else begin
      // result beat loaded or taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            alpha_neg_q <= in_i.volt_alpha[VOLT_W-1];
            beta_q      <= in_i.volt_beta;
            state_q     <= ST_MUL;
          end
        end
        // wait for |alpha|*sqrt3/2, keep both signs of it
        ST_MUL: begin
          if (mul0_done) begin
            p_q     <= alpha_neg_q ? -prod_s : prod_s;
            pn_q    <= alpha_neg_q ? prod_s : -prod_s;
            state_q <= ST_UVEC;
          end
        end
        // reference voltages in Q28
        ST_UVEC: begin
          u1_q    <= beta_q28;
          u2_q    <= pn_q - beta_q27;
          u3_q    <= p_q - beta_q27;
          state_q <= ST_QSEL;
        end
        ST_QSEL: begin
          code_q  <= code_d;
          qx_q    <= qx_d;
          qy_q    <= qy_d;
          state_q <= ST_TIME;
        end
        ST_TIME: begin
          tx_q    <= round_q14(qx_q);
          ty_q    <= round_q14(qy_q);
          state_q <= ST_CHECK;
        end
        // zero vector holds, long vector gets scaled
        ST_CHECK: begin
          if ((code_q == SECT_NONE) || (code_q == SECT_ALL)) begin
            over_q  <= 1'b0;
            hold_q  <= 1'b1;
            state_q <= ST_DUTY;
          end else if (sum_t > SUM_W'(PERIOD)) begin
            over_q     <= 1'b1;
            hold_q     <= 1'b0;
            div_den_q  <= sum_t;
            div_rem_q  <= SUM_W'(ROUND_HALF);
            div_quot_q <= '0;
            div_cnt_q  <= DIV_CNT_W'(DIV_STEPS);
            state_q    <= ST_DIV;
          end else begin
            over_q  <= 1'b0;
            hold_q  <= 1'b0;
            state_q <= ST_ZERO;
          end
        end
        // one quotient bit per cycle, multipliers start on the last one
        ST_DIV: begin
          div_rem_q  <= div_rem_d;
          div_quot_q <= div_quot_d;
          div_cnt_q  <= div_cnt_q - 1'b1;
          if (div_last) begin
            last_scale_q <= div_quot_d;
            state_q      <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (mul0_done && mul1_done) begin
            tx_q    <= mul0_prod[FRAC_W +: TIME_W];
            ty_q    <= mul1_prod[FRAC_W +: TIME_W];
            state_q <= ST_ZERO;
          end
        end
        // half of the remaining zero time
        ST_ZERO: begin
          sxy_q   <= sum_s[DUTY_W-1:0];
          t7_q    <= zero_t[DUTY_W:1];
          state_q <= ST_DUTY;
        end
        ST_DUTY: begin
          if (out_free) begin
            out_code_q  <= code_q;
            out_over_q  <= over_q;
            out_scale_q <= last_scale_q;
            if (hold_q) begin
              out_a_q <= held_a_q;
              out_b_q <= held_b_q;
              out_c_q <= held_c_q;
            end else begin
              held_a_q <= duty_a_d;
              held_b_q <= duty_b_d;
              held_c_q <= duty_c_d;
              out_a_q  <= duty_a_d;
              out_b_q  <= duty_b_d;
              out_c_q  <= duty_c_d;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.duty_a        = out_a_q;
  assign out_o.duty_b        = out_b_q;
  assign out_o.duty_c        = out_c_q;
  assign out_o.sector_code   = out_code_q;
  assign out_o.overmodulated = out_over_q;
  assign out_o.scale_factor  = out_scale_q;

endmodule
